FILE: sv/text_console_character_engine_assert.svh
// Assertion macros for the text console character engine.
// Each macro takes a label, the clock, the active-low reset, a condition
// and the property that must follow from it.
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Property holds in the same cycle as the condition.
`define TCE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console assertion failed");
// Property holds in the cycle after the condition.
`define TCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console assertion failed");
`else
`define TCE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/tce_pkg.sv
package tce_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] RESET_ATTR   = 8'h0F;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic sweep;
        logic sweep_all;
        logic top_advance;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scroll_needed;
        logic sweep_col_last;
        logic sweep_row_last;
    } t_sts;

endpackage

FILE: sv/text_console_character_engine.sv
// Text console character engine: a screen of ROWS x COLUMNS 16-bit cells
// (character in the low byte, attribute in the high byte) and a cursor.
// Input channel (i_in_valid / o_in_ready) carries one request: a put of
// i_char_code at the cursor, with newline, return, tab and backspace
// interpreted, or a read of the cell at i_read_row / i_read_col.
// Output channel (o_out_valid / i_out_ready) returns one result per request:
// the cell read (zero for a put or an off-screen read) and the cursor.
// The attribute for written and blanked cells is set through i_cfg_we and
// i_cfg_wdata; write it only while no request is in flight.
// After a request is accepted the controller moves to its done state, which
// loads the result register once it is free; a put that leaves the last row
// first passes a scroll state that blanks the freed row, one cell a cycle,
// since scrolling only moves the top-row pointer of the row ring. The
// controller takes no new request until the last one's result is loaded.
// After reset the screen memory is swept to blank white on black, one cell
// a cycle over all ROWS x COLUMNS cells (2000 by default); no request is taken
// during the sweep, although the attribute register may be written.
// If the receiver stalls, the result waits in the output register; one
// further request may be accepted and is held until the result is taken.
module text_console_character_engine
    import tce_pkg::*;
#(
    parameter  int COLUMNS = DEF_COLUMNS,
    parameter  int ROWS    = DEF_ROWS,
    localparam int RW      = $clog2(ROWS),
    localparam int CW      = $clog2(COLUMNS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_req_type,
    input  logic [7:0]    i_char_code,
    input  logic [RW-1:0] i_read_row,
    input  logic [CW-1:0] i_read_col,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [15:0]   o_cell_entry,
    output logic [RW-1:0] o_cursor_row,
    output logic [CW-1:0] o_cursor_col,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata
);

    // Commands and status between the controller and the datapath.
    t_cmd cmd;
    t_sts sts;

    // The controller sequences the reset sweep, request acceptance, the
    // row blanking after a scroll and the hand-over to the output register.
    tce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the screen memory, the cursor, the row ring
    // pointer, the attribute register and the result register.
    tce_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_cell_entry (o_cell_entry),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

endmodule

FILE: sv/tce_ctrl.sv
`include "text_console_character_engine_assert.svh"

module tce_ctrl
    import tce_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.sweep_col_last && i_sts.sweep_row_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.scroll_needed ? ST_SCROLL : ST_DONE;
                end
            end
            ST_SCROLL: begin
                if (i_sts.sweep_col_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.sweep     = 1'b1;
                o_cmd.sweep_all = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_SCROLL: begin
                o_cmd.sweep       = 1'b1;
                o_cmd.top_advance = i_sts.sweep_col_last;
            end
            ST_DONE: begin
                o_cmd.load_out = !r_out_valid || i_out_ready;
            end
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

    `TCE_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, o_cmd.accept,
        r_state == ST_DONE || r_state == ST_SCROLL)
    `TCE_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.load_out, r_out_valid)
    `TCE_ASSERT_SAME(a_no_result_in_clear, i_clk, i_rst_n, r_state == ST_CLEAR, !r_out_valid)

endmodule

FILE: sv/tce_dp.sv
`include "text_console_character_engine_assert.svh"

module tce_dp
    import tce_pkg::*;
#(
    parameter  int COLUMNS = DEF_COLUMNS,
    parameter  int ROWS    = DEF_ROWS,
    localparam int RW      = $clog2(ROWS),
    localparam int CW      = $clog2(COLUMNS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_sts          o_sts,
    input  logic          i_req_type,
    input  logic [7:0]    i_char_code,
    input  logic [RW-1:0] i_read_row,
    input  logic [CW-1:0] i_read_col,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    output logic [15:0]   o_cell_entry,
    output logic [RW-1:0] o_cursor_row,
    output logic [CW-1:0] o_cursor_col
);

    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    localparam logic [RW:0]   ROWS_W   = (RW + 1)'(ROWS);
    localparam logic [CW:0]   COLS_W   = (CW + 1)'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

    logic [15:0]   mem [DEPTH];

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_top;
    logic [7:0]    r_color;
    logic [RW-1:0] r_sweep_row;
    logic [CW-1:0] r_sweep_col;
    logic [15:0]   r_rdata;
    logic          r_is_read;
    logic          r_in_range;
    logic [15:0]   r_out_cell;
    logic [RW-1:0] r_out_row;
    logic [CW-1:0] r_out_col;

    logic [RW-1:0] n_row;
    logic [CW-1:0] n_col;
    logic          next_row;
    logic          wr_put;
    logic [CW-1:0] wr_col;
    logic [7:0]    wr_char;
    logic [CW:0]   col_inc;
    logic [CW:0]   tab_pos;
    logic          is_put;
    logic          scroll;
    logic [RW:0]   cur_sum;
    logic [RW:0]   cur_phys;
    logic [RW:0]   rd_sum;
    logic [RW:0]   rd_phys;
    logic          in_range;
    logic          rd_en;
    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;

    assign is_put  = (i_req_type == REQ_PUT);
    assign col_inc = {1'b0, r_col} + (CW + 1)'(1);
    assign tab_pos = ({1'b0, r_col} + (CW + 1)'(4)) & ~(CW + 1)'(3);

    // Control character decode and cursor update.
    always_comb begin
        n_col    = r_col;
        next_row = 1'b0;
        wr_put   = 1'b0;
        wr_col   = r_col;
        wr_char  = i_char_code;
        unique case (i_char_code)
            CH_NEWLINE: begin
                next_row = 1'b1;
                n_col    = '0;
            end
            CH_RETURN: begin
                n_col = '0;
            end
            CH_TAB: begin
                if (tab_pos >= COLS_W) begin
                    next_row = 1'b1;
                    n_col    = '0;
                end else begin
                    n_col = tab_pos[CW-1:0];
                end
            end
            CH_BACKSPACE: begin
                if (r_col != '0) begin
                    n_col   = r_col - CW'(1);
                    wr_put  = 1'b1;
                    wr_col  = r_col - CW'(1);
                    wr_char = CH_SPACE;
                end
            end
            default: begin
                wr_put = 1'b1;
                if (col_inc >= COLS_W) begin
                    next_row = 1'b1;
                    n_col    = '0;
                end else begin
                    n_col = col_inc[CW-1:0];
                end
            end
        endcase
    end

    assign scroll = next_row && (r_row == LAST_ROW);
    assign n_row  = (next_row && !scroll) ? r_row + RW'(1) : r_row;

    // Screen rows are kept as a ring; r_top is the stored row shown on top.
    assign cur_sum  = {1'b0, r_row} + {1'b0, r_top};
    assign cur_phys = (cur_sum >= ROWS_W) ? cur_sum - ROWS_W : cur_sum;
    assign rd_sum   = {1'b0, i_read_row} + {1'b0, r_top};
    assign rd_phys  = (rd_sum >= ROWS_W) ? rd_sum - ROWS_W : rd_sum;
    assign in_range = ({1'b0, i_read_row} < ROWS_W) && ({1'b0, i_read_col} < COLS_W);
    assign rd_en    = i_cmd.accept && !is_put && in_range;

    always_comb begin
        if (i_cmd.sweep) begin
            we    = 1'b1;
            waddr = {(i_cmd.sweep_all ? r_sweep_row : r_top), r_sweep_col};
            wdata = {(i_cmd.sweep_all ? RESET_ATTR : r_color), CH_SPACE};
        end else begin
            we    = i_cmd.accept && is_put && wr_put;
            waddr = {cur_phys[RW-1:0], wr_col};
            wdata = {r_color, wr_char};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[{rd_phys[RW-1:0], i_read_col}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_color     <= RESET_ATTR;
            r_sweep_row <= '0;
            r_sweep_col <= '0;
        end else begin
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
            if (i_cmd.accept && is_put) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (i_cmd.top_advance) begin
                r_top <= (r_top == LAST_ROW) ? '0 : r_top + RW'(1);
            end
            if (i_cmd.sweep) begin
                if (r_sweep_col == LAST_COL) begin
                    r_sweep_col <= '0;
                    if (i_cmd.sweep_all) begin
                        r_sweep_row <= (r_sweep_row == LAST_ROW) ? '0 : r_sweep_row + RW'(1);
                    end
                end else begin
                    r_sweep_col <= r_sweep_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_read  <= !is_put;
            r_in_range <= in_range;
        end
        if (i_cmd.load_out) begin
            r_out_cell <= (r_is_read && r_in_range) ? r_rdata : '0;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
        end
    end

    assign o_sts.scroll_needed  = is_put && scroll;
    assign o_sts.sweep_col_last = (r_sweep_col == LAST_COL);
    assign o_sts.sweep_row_last = (r_sweep_row == LAST_ROW);

    assign o_cell_entry = r_out_cell;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;

    `TCE_ASSERT_NEXT(a_scroll_keeps_last_row, i_clk, i_rst_n,
        i_cmd.accept && o_sts.scroll_needed, r_row == LAST_ROW && r_col == '0)
    `TCE_ASSERT_NEXT(a_scroll_sweep_ends_at_col0, i_clk, i_rst_n,
        i_cmd.top_advance, r_sweep_col == '0)
    `TCE_ASSERT_SAME(a_sweep_not_with_request, i_clk, i_rst_n, i_cmd.sweep, !i_cmd.accept)

endmodule

FILE: tb/tb_text_console_character_engine.sv
module tb_text_console_character_engine
    import tce_pkg::*;
();

    // The screen geometry follows the block's default parameters.
    localparam int COLS         = DEF_COLUMNS;
    localparam int ROWS_N       = DEF_ROWS;
    localparam int SCREEN_CELLS = COLS * ROWS_N;

    // Generous cycle budget. It covers the clearing sweep after
    // reset and about a thousand requests, each allowed a scroll, a long
    // sender gap and a long receiver stall, many times over.
    localparam int unsigned CYCLE_LIMIT = 400000;

    // One result as the block reports it.
    typedef struct packed {
        logic [15:0] entry;
        logic [4:0]  row;
        logic [6:0]  col;
    } t_console_reply;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic        i_req_type   = REQ_PUT;
    logic [7:0]  i_char_code  = 8'd0;
    logic [4:0]  i_read_row   = 5'd0;
    logic [6:0]  i_read_col   = 7'd0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [15:0] o_cell_entry;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_col;
    logic        i_cfg_we     = 1'b0;
    logic [7:0]  i_cfg_wdata  = 8'd0;

    // Our own copy of the console: the screen, the cursor and the attribute.
    logic [15:0] shadow_screen [SCREEN_CELLS];
    int          shadow_row;
    int          shadow_col;
    logic [7:0]  shadow_attr;

    // Results predicted at acceptance, oldest first.
    t_console_reply predicted_replies [$];

    // Idle percentages for the two sides of the handshake.
    int send_idle_pct;
    int recv_idle_pct;

    int          error_count;
    int          request_count;
    int          put_count;
    int          read_count;
    int          reply_count;
    int          scroll_count;
    int          colour_count;
    int unsigned cycle_count;

    text_console_character_engine u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cell_entry (o_cell_entry),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake must not let the run go on for ever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results still awaited.",
                     cycle_count, predicted_replies.size());
            $display("tb_text_console_character_engine: FAIL");
            $finish;
        end
    end

    // The receiver drops ready at random in the configured share of cycles.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Row advance. Leaving the bottom row scrolls the whole screen up by one
    // line, blanks the freed bottom row in the current attribute and keeps
    // the cursor on the last row.
    function automatic void shadow_next_row();
        shadow_col = 0;
        if (shadow_row + 1 >= ROWS_N) begin
            for (int i = 0; i + COLS < SCREEN_CELLS; i++)
                shadow_screen[i] = shadow_screen[i + COLS];
            for (int i = (ROWS_N - 1) * COLS; i < SCREEN_CELLS; i++)
                shadow_screen[i] = {shadow_attr, CH_SPACE};
            shadow_row = ROWS_N - 1;
            scroll_count++;
        end else begin
            shadow_row++;
        end
    endfunction

    // Applies one accepted request to the shadow console and returns the
    // result that the block must report for it.
    function automatic t_console_reply apply_console_request(
        logic req, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
        t_console_reply reply;
        reply.entry = 16'd0;
        if (req == REQ_PUT) begin
            put_count++;
            if (ch == CH_NEWLINE) begin
                shadow_next_row();
            end else if (ch == CH_RETURN) begin
                shadow_col = 0;
            end else if (ch == CH_TAB) begin
                shadow_col = (shadow_col + 4) & ~3;
                if (shadow_col >= COLS)
                    shadow_next_row();
            end else if (ch == CH_BACKSPACE) begin
                // Backspace at the left margin is simply ignored.
                if (shadow_col > 0) begin
                    shadow_col--;
                    shadow_screen[shadow_row * COLS + shadow_col] = {shadow_attr, CH_SPACE};
                end
            end else begin
                shadow_screen[shadow_row * COLS + shadow_col] = {shadow_attr, ch};
                shadow_col++;
                if (shadow_col >= COLS)
                    shadow_next_row();
            end
        end else begin
            read_count++;
            // Reads beyond the screen return an empty cell.
            if (rr < ROWS_N && rc < COLS)
                reply.entry = shadow_screen[rr * COLS + rc];
        end
        reply.row = shadow_row[4:0];
        reply.col = shadow_col[6:0];
        return reply;
    endfunction

    // Sends one request. Valid is left high on return so that a following
    // request without a gap keeps it high; quiesce_console lowers it.
    task automatic send_request(logic req, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_char_code <= ch;
        i_read_row  <= rr;
        i_read_col  <= rc;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        predicted_replies.push_back(apply_console_request(req, ch, rr, rc));
        request_count++;
    endtask

    // A put request; the read coordinates carry noise, which the block ignores.
    task automatic put_char(logic [7:0] ch);
        send_request(REQ_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
    endtask

    // A read request; the character byte carries noise.
    task automatic read_cell(logic [4:0] rr, logic [6:0] rc);
        send_request(REQ_READ, 8'($urandom_range(0, 255)), rr, rc);
    endtask

    // Withdraws the request line and waits until every result has come back,
    // so that the block is idle.
    task automatic quiesce_console();
        i_in_valid <= 1'b0;
        while (predicted_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // Writes the attribute register while the block is idle.
    task automatic set_text_colour(logic [7:0] attr);
        quiesce_console();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= attr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_attr = attr;
        colour_count++;
    endtask

    // Each result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_console_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            reply_count++;
            if (predicted_replies.size() == 0) begin
                $error("result with no request outstanding: cell %h cursor %0d,%0d",
                       o_cell_entry, o_cursor_row, o_cursor_col);
                error_count++;
            end else begin
                want = predicted_replies.pop_front();
                if (o_cell_entry !== want.entry) begin
                    $error("cell_entry: expected %h, got %h", want.entry, o_cell_entry);
                    error_count++;
                end
                if (o_cursor_row !== want.row) begin
                    $error("cursor_row: expected %0d, got %0d", want.row, o_cursor_row);
                    error_count++;
                end
                if (o_cursor_col !== want.col) begin
                    $error("cursor_col: expected %0d, got %0d", want.col, o_cursor_col);
                    error_count++;
                end
            end
        end
    end

    // After reset the first and last cells must be white-on-black blanks, and reads off
    // the screen must come back empty.
    task automatic test_power_on_screen();
        read_cell(5'd0, 7'd0);
        read_cell(5'(ROWS_N - 1), 7'(COLS - 1));
        read_cell(5'(ROWS_N), 7'd0);
        read_cell(5'd0, 7'(COLS));
        read_cell(5'd31, 7'd127);
    endtask

    // Each control character, the byte extremes, and a put whose unused
    // read coordinates are all ones.
    task automatic test_control_codes();
        put_char(CH_BACKSPACE);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_TAB);
        put_char(CH_BACKSPACE);
        put_char(CH_RETURN);
        put_char(CH_NEWLINE);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        read_cell(5'd0, 7'd3);
        send_request(REQ_PUT, 8'h41, 5'd31, 7'd127);
    endtask

    // Written and blanked cells take the attribute in force at the time.
    task automatic test_colour_register();
        set_text_colour(8'h00);
        put_char(8'h78);
        read_cell(5'd1, 7'd1);
        set_text_colour(8'hFF);
        put_char(CH_BACKSPACE);
        read_cell(5'd1, 7'd1);
    endtask

    // Random text laid out as lines: bursts of characters with reads mixed
    // in, closed by a line ending, tabs, backspaces or a run to the right
    // margin followed by a tab, or left open. Long lines wrap and the screen
    // scrolls often. The next attribute setting waits for every result.
    task automatic test_random_lines(int budget, int sender_pct, int receiver_pct);
        int stop_at;
        int len;
        int ending;
        int target;
        int pick;
        set_text_colour(8'($urandom_range(0, 255)));
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        stop_at = request_count + budget;
        while (request_count < stop_at) begin
            len = ($urandom_range(0, 9) < 2) ? $urandom_range(60, 100) : $urandom_range(0, 24);
            for (int k = 0; k < len && request_count < stop_at; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45)
                        read_cell(shadow_row[4:0], 7'($urandom_range(0, COLS - 1)));
                    else if (pick < 85)
                        read_cell(5'($urandom_range(0, ROWS_N - 1)),
                                  7'($urandom_range(0, COLS - 1)));
                    else
                        read_cell(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
                end else if (pick < 20) begin
                    put_char(8'($urandom_range(0, 255)));
                end else begin
                    put_char(8'($urandom_range(33, 126)));
                end
            end
            ending = $urandom_range(0, 11);
            case (ending)
                3: begin
                    put_char(CH_RETURN);
                    put_char(CH_NEWLINE);
                end
                4: begin
                    put_char(CH_RETURN);
                end
                5: begin
                    repeat ($urandom_range(1, 3)) put_char(CH_TAB);
                end
                6: begin
                    repeat ($urandom_range(1, 6)) put_char(CH_BACKSPACE);
                end
                7: begin
                    // Line left open; the next burst continues it.
                end
                8: begin
                    // Fill to just short of the right margin, then tab over it.
                    target = COLS - 4 + $urandom_range(0, 3);
                    while (shadow_col < target)
                        put_char(8'($urandom_range(33, 126)));
                    put_char(CH_TAB);
                end
                default: begin
                    put_char(CH_NEWLINE);
                end
            endcase
        end
    endtask

    initial begin
        for (int i = 0; i < SCREEN_CELLS; i++)
            shadow_screen[i] = {RESET_ATTR, CH_SPACE};
        shadow_row    = 0;
        shadow_col    = 0;
        shadow_attr   = RESET_ATTR;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        error_count   = 0;
        request_count = 0;
        put_count     = 0;
        read_count    = 0;
        reply_count   = 0;
        scroll_count  = 0;
        colour_count  = 0;
        cycle_count   = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block refuses requests during its clearing sweep; the
        // handshake simply waits it out.
        test_power_on_screen();
        test_control_codes();
        test_colour_register();
        test_random_lines(310, 19, 70);
        test_random_lines(310, 70, 19);
        test_random_lines(310, 0, 0);
        set_text_colour(RESET_ATTR);

        // Allow time for any stray result beyond the longest scroll.
        repeat (100) @(posedge i_clk);

        $display("Covered %0d requests (%0d puts, %0d reads), %0d results checked,",
                 request_count, put_count, read_count, reply_count);
        $display("%0d screen scrolls and %0d attribute settings, %0d mismatches.",
                 scroll_count, colour_count, error_count);
        if (error_count == 0 && predicted_replies.size() == 0) begin
            $display("tb_text_console_character_engine: PASS");
        end else begin
            $display("tb_text_console_character_engine: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/tce_pkg.sv
sv/tce_ctrl.sv
sv/tce_dp.sv
sv/text_console_character_engine.sv
tb/tb_text_console_character_engine.sv
